@@ hw/rtl/clws_pkg.sv @@
// ----------------------------------------------------------------------------
// clws_pkg
// shared types, constants and state encoding of the character lcd write
// sequencer
// ----------------------------------------------------------------------------
package clws_pkg;

  // defaults for the top level parameters
  localparam int LINE_TWO_BASE_DEF = 64;
  localparam int MAX_DIGITS_DEF    = 10;

  // width of the number field
  localparam int NUM_W = 32;

  // bus writes per request are capped, later writes are dropped
  localparam int MAX_WRITES = 40;
  localparam int WCNT_W     = $clog2(MAX_WRITES + 1);

  // lcd controller codes
  localparam logic [7:0] CMD_RETURN_HOME = 8'h02;
  localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;
  localparam logic [7:0] WRAP_ADDRESS    = 8'h10;
  localparam logic [7:0] END_ADDRESS     = 8'h4F;
  localparam logic [7:0] NIBBLE_MASK     = 8'h0F;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;

  // request kinds
  typedef enum logic [1:0] {
    MODE_COMMAND = 2'd0,
    MODE_CHAR    = 2'd1,
    MODE_MOVE    = 2'd2,
    MODE_NUMBER  = 2'd3
  } mode_t;

  // request word
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  byte_value;
    logic [1:0]  row;
    logic [5:0]  column;
    logic [31:0] number;
  } req_t;

  // bus write word
  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic       last;
  } wr_t;

  // one byte handed from the sequencer to the bus write stage
  typedef struct packed {
    logic       first;
    logic       is_final;
    logic       reg_select;
    logic [7:0] value;
  } byte_cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_COMMAND,
    S_MOVE,
    S_CONVERT,
    S_SKIP,
    S_DIGIT,
    S_WRAP,
    S_HOME,
    S_DATA
  } seq_state_t;

endpackage

@@ hw/rtl/char_lcd_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// requests: one at a time; the request side stalls until the state walk is back
//   in idle; a number request first runs the shift-add-3 converter, then skips
//   leading zeros and prints one digit at a time; line wraps, return home and
//   output stalls lengthen the walk
// reset: synchronous, clears the sequencer, the cursor counter and the bus
//   width register (4-bit bus)
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer #(
  parameter int LINE_TWO_BASE = clws_pkg::LINE_TWO_BASE_DEF,
  parameter int MAX_DIGITS    = clws_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // bus width register
  input  logic           cfg_write_en,
  input  logic           cfg_data,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  clws_pkg::req_t req,
  // bus write channel
  output logic           wr_valid,
  input  logic           wr_stall,
  output clws_pkg::wr_t  wr
);
  import clws_pkg::*;

  localparam int         PTR_W         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [6:0] LINE_TWO_ADDR = 7'(LINE_TWO_BASE);

  // configuration
  logic eight_bit_bus;

  // sequencer
  seq_state_t        state;
  seq_state_t        state_next;
  logic [7:0]        cursor;
  mode_t             cur_mode;
  logic [7:0]        cur_byte;    // command, character, digit or target address
  logic [PTR_W-1:0]  ptr;         // digit being printed
  logic              first_byte;  // next byte opens the request

  // converter
  logic                    conv_start;
  logic                    conv_busy;
  logic [4*MAX_DIGITS-1:0] bcd;
  logic                    overflow;
  logic [3:0]              digit_sel;

  // byte handoff
  logic      issue_valid;
  byte_cmd_t issue;
  logic      byte_ready;
  logic      issue_fire;

  logic      accept;
  logic [7:0] move_sum;
  logic [6:0] move_addr;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign conv_start = accept && (req.mode == MODE_NUMBER);
  assign digit_sel  = bcd[{ptr, 2'b00} +: 4];
  assign issue_fire = issue_valid && byte_ready;

  // cursor position for a move request
  always_comb begin
    if (req.row < 2'd2 && req.column < 6'd16) begin
      move_sum = req.row[0] ? ({1'b0, LINE_TWO_ADDR} + {2'b00, req.column})
                            : {2'b00, req.column};
    end else if (req.row > 2'd1) begin
      move_sum = {1'b0, LINE_TWO_ADDR} + {2'b00, req.column};
    end else if (req.column > 6'd16) begin
      // columns past the first line fold onto line two
      move_sum = {1'b0, LINE_TWO_ADDR} + {4'b0000, req.column[3:0]};
    end else begin
      // column sixteen of the first lines lands at home
      move_sum = 8'h00;
    end
    move_addr = move_sum[6:0];
  end

  clws_bcd_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_bcd_conv (
    .clk      (clk),
    .rst      (rst),
    .start    (conv_start),
    .value    (req.number),
    .busy     (conv_busy),
    .bcd      (bcd),
    .overflow (overflow)
  );

  clws_byte_tx u_byte_tx (
    .clk           (clk),
    .rst           (rst),
    .eight_bit_bus (eight_bit_bus),
    .cmd_valid     (issue_valid),
    .cmd           (issue),
    .ready         (byte_ready),
    .wr_valid      (wr_valid),
    .wr_stall      (wr_stall),
    .wr            (wr)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE: begin
        if (accept) begin
          unique case (req.mode)
            MODE_COMMAND: state_next = S_COMMAND;
            MODE_CHAR:    state_next = S_WRAP;
            MODE_MOVE:    state_next = S_MOVE;
            MODE_NUMBER:  state_next = S_CONVERT;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_COMMAND, S_MOVE: begin
        if (byte_ready) begin
          state_next = S_IDLE;
        end
      end
      S_CONVERT: begin
        if (!conv_busy) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        // leading zeros go unless the value ran past the digit limit
        if (overflow || digit_sel != 4'd0 || ptr == '0) begin
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: state_next = S_WRAP;
      S_WRAP: begin
        if (!issue_valid || byte_ready) begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        if (!issue_valid || byte_ready) begin
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        if (byte_ready) begin
          if (cur_mode == MODE_NUMBER && ptr != '0) begin
            state_next = S_DIGIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // byte offered to the write stage
  always_comb begin
    issue_valid      = 1'b0;
    issue.first      = first_byte;
    issue.is_final   = 1'b0;
    issue.reg_select = 1'b0;
    issue.value      = cur_byte;
    unique case (state)
      S_COMMAND: begin
        issue_valid    = 1'b1;
        issue.is_final = 1'b1;
      end
      S_MOVE: begin
        issue_valid    = 1'b1;
        issue.is_final = 1'b1;
        issue.value    = CMD_SET_ADDRESS | {1'b0, cur_byte[6:0]};
      end
      S_WRAP: begin
        // end of line one: jump to the start of line two first
        issue_valid = (cursor == WRAP_ADDRESS);
        issue.value = CMD_SET_ADDRESS | {1'b0, LINE_TWO_ADDR};
      end
      S_HOME: begin
        // past the end of the display: return home
        issue_valid = (cursor > END_ADDRESS);
        issue.value = CMD_RETURN_HOME;
      end
      S_DATA: begin
        issue_valid      = 1'b1;
        issue.reg_select = 1'b1;
        issue.is_final   = (cur_mode == MODE_CHAR) || (ptr == '0);
      end
      default: begin
        issue_valid = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      eight_bit_bus <= 1'b0;
      cursor        <= 8'h00;
      first_byte    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        eight_bit_bus <= cfg_data;
      end
      if (accept) begin
        first_byte <= 1'b1;
      end else if (issue_fire) begin
        first_byte <= 1'b0;
      end
      if (issue_fire) begin
        case (state)
          S_MOVE:  cursor <= {1'b0, cur_byte[6:0]};
          S_WRAP:  cursor <= {1'b0, LINE_TWO_ADDR};
          S_HOME:  cursor <= 8'h00;
          S_DATA:  cursor <= cursor + 8'd1;
          default: cursor <= cursor;
        endcase
      end
    end
  end

  // request payload and digit walk
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode <= req.mode;
      cur_byte <= (req.mode == MODE_MOVE) ? {1'b0, move_addr} : req.byte_value;
    end
    if (state == S_CONVERT && !conv_busy) begin
      ptr <= PTR_W'(MAX_DIGITS - 1);
    end
    if (state == S_SKIP && state_next == S_SKIP) begin
      ptr <= ptr - 1'b1;
    end
    if (state == S_DIGIT) begin
      cur_byte <= CHAR_ZERO | {4'b0000, digit_sel};
    end
    if (state == S_DATA && byte_ready && cur_mode == MODE_NUMBER && ptr != '0) begin
      ptr <= ptr - 1'b1;
    end
  end

endmodule

@@ hw/rtl/clws_bcd_conv.sv @@
// ----------------------------------------------------------------------------
// clws_bcd_conv
// iterative binary to bcd converter, one shift-add-3 step per cycle; keeps
// the low MAX_DIGITS digits and flags a value that needs more of them
// ----------------------------------------------------------------------------
module clws_bcd_conv #(
  parameter int MAX_DIGITS = clws_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [clws_pkg::NUM_W-1:0]  value,
  output logic                        busy,
  output logic [4*MAX_DIGITS-1:0]     bcd,
  output logic                        overflow
);
  import clws_pkg::*;

  localparam int BCD_W     = 4 * MAX_DIGITS;
  localparam int BIT_CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]     bin;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [BCD_W-1:0]     adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    adj = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bit_cnt == BIT_CNT_W'(NUM_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin      <= value;
      bcd      <= '0;
      overflow <= 1'b0;
      bit_cnt  <= '0;
    end else if (busy) begin
      bcd      <= {adj[BCD_W-2:0], bin[NUM_W-1]};
      overflow <= overflow | adj[BCD_W-1];
      bin      <= {bin[NUM_W-2:0], 1'b0};
      bit_cnt  <= bit_cnt + 1'b1;
    end
  end

endmodule

@@ hw/rtl/clws_byte_tx.sv @@
// ----------------------------------------------------------------------------
// clws_byte_tx
// bus write stage: splits a byte into nibbles on the 4-bit bus, counts the
// writes of a request, drops those past the cap and marks the last one
// ----------------------------------------------------------------------------
module clws_byte_tx (
  input  logic                clk,
  input  logic                rst,
  input  logic                eight_bit_bus,
  input  logic                cmd_valid,
  input  clws_pkg::byte_cmd_t cmd,
  output logic                ready,
  output logic                wr_valid,
  input  logic                wr_stall,
  output clws_pkg::wr_t       wr
);
  import clws_pkg::*;

  logic              busy;
  logic              low_phase;
  byte_cmd_t         cur;
  logic [WCNT_W-1:0] wcnt;
  logic              out_free;
  logic              last_piece;
  logic              capped;
  logic              advance;
  wr_t               word;

  assign ready      = !busy;
  assign out_free   = !wr_valid || !wr_stall;
  assign last_piece = eight_bit_bus || low_phase;
  assign capped     = (wcnt == WCNT_W'(MAX_WRITES));
  assign advance    = busy && (capped || out_free);

  always_comb begin
    word.reg_select = cur.reg_select;
    if (eight_bit_bus) begin
      word.bus_value = cur.value;
    end else if (low_phase) begin
      word.bus_value = cur.value & NIBBLE_MASK;
    end else begin
      word.bus_value = {4'b0000, cur.value[7:4]};
    end
    word.last = (cur.is_final && last_piece) || (wcnt == WCNT_W'(MAX_WRITES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      low_phase <= 1'b0;
      wr_valid  <= 1'b0;
      wcnt      <= '0;
    end else begin
      if (advance && !capped) begin
        wr_valid <= 1'b1;
      end else if (!wr_stall) begin
        wr_valid <= 1'b0;
      end
      if (cmd_valid && !busy) begin
        busy      <= 1'b1;
        low_phase <= 1'b0;
        if (cmd.first) begin
          wcnt <= '0;
        end
      end else if (advance) begin
        if (last_piece) begin
          busy <= 1'b0;
        end else begin
          low_phase <= 1'b1;
        end
        if (!capped) begin
          wcnt <= wcnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !busy) begin
      cur <= cmd;
    end
    if (advance && !capped) begin
      wr <= word;
    end
  end

endmodule

@@ hw/rtl/clws_checker.sv @@
// ----------------------------------------------------------------------------
// clws_checker
// port level checks of the character lcd write sequencer, bound to the top
// ----------------------------------------------------------------------------
module clws_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          wr_valid,
  input logic          wr_stall,
  input clws_pkg::wr_t wr
);
  import clws_pkg::*;

  // a stalled write word holds
  a_wr_hold: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_stall |=> wr_valid && $stable(wr))
    else $error("stalled write word changed");

  // an accepted request always keeps the block busy for the next cycle
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken without going busy");

  // reset leaves no write pending and the request side open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !wr_valid && !req_stall)
    else $error("reset did not clear the block");

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .wr_valid  (wr_valid),
  .wr_stall  (wr_stall),
  .wr        (wr)
);
